// ===== src/pcen_pkg.sv =====
// ----------------------------------------------------------------------------
// pcen_pkg: shared types and constants of the polygon centroid block
// Word formats of the vertex and result channels, and result method codes.
// ----------------------------------------------------------------------------
package pcen_pkg;

  localparam int COORD_W  = 16;
  localparam int METHOD_W = 3;

  localparam logic [METHOD_W-1:0] METH_AREA  = 3'd0;
  localparam logic [METHOD_W-1:0] METH_BOX   = 3'd1;
  localparam logic [METHOD_W-1:0] METH_POINT = 3'd2;
  localparam logic [METHOD_W-1:0] METH_MID   = 3'd3;
  localparam logic [METHOD_W-1:0] METH_OVER  = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_vertex;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [METHOD_W-1:0]       method;
  } out_word_t;

endpackage

// ===== src/pcen_mul.sv =====
// ----------------------------------------------------------------------------
// pcen_mul: bit-serial signed multiplier
// Shift-add over the multiplier bits, most significant first, one bit a cycle.
// ----------------------------------------------------------------------------
module pcen_mul #(
  parameter int MC_W = 33,
  parameter int MP_W = 17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [MC_W-1:0]        mcand,
  input  logic signed [MP_W-1:0]        mplier,
  output logic                          done,
  output logic signed [MC_W+MP_W-1:0]   product
);

  localparam int PR_W  = MC_W + MP_W;
  localparam int CNT_W = $clog2(MP_W);

  logic                    busy_r;
  logic                    done_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [MC_W-1:0]  mc_r;
  logic [MP_W-1:0]         mp_r;
  logic signed [PR_W-1:0]  acc_r;
  logic signed [PR_W-1:0]  term;
  logic signed [PR_W-1:0]  acc_shl;
  logic signed [PR_W-1:0]  acc_nxt;
  logic                    first_bit;

  always_comb begin
    term      = mp_r[MP_W-1] ? PR_W'(mc_r) : '0;
    first_bit = (cnt_r == CNT_W'(MP_W - 1));
    acc_shl   = {acc_r[PR_W-2:0], 1'b0};
    acc_nxt   = first_bit ? (acc_shl - term) : (acc_shl + term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MP_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r  <= mcand;
      mp_r  <= mplier;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      mp_r  <= {mp_r[MP_W-2:0], 1'b0};
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== src/pcen_div.sv =====
// ----------------------------------------------------------------------------
// pcen_div: serial signed divider with saturation
// Restoring division on magnitudes, one quotient bit a cycle; the quotient
// truncates toward zero and saturates to the Q_W-bit signed range.
// ----------------------------------------------------------------------------
module pcen_div #(
  parameter int NUM_W = 58,
  parameter int DEN_W = 43,
  parameter int Q_W   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [Q_W-1:0]   quot
);

  localparam int XW    = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int CNT_W = $clog2(Q_W + 1);
  localparam logic [Q_W:0] POS_MAX = (Q_W+1)'((1 << (Q_W - 1)) - 1);
  localparam logic [Q_W:0] NEG_MAG = (Q_W+1)'(1 << (Q_W - 1));

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [XW-1:0]    rem_r;
  logic [XW-1:0]    dsh_r;
  logic [Q_W:0]     q_r;
  logic             neg_r;
  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic             ge;

  always_comb begin
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    ge      = (rem_r >= dsh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= XW'(num_mag);
      dsh_r <= XW'(den_mag) << Q_W;
      q_r   <= '0;
      neg_r <= num[NUM_W-1] ^ den[DEN_W-1];
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[Q_W-1:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  always_comb begin
    if (!neg_r) begin
      quot = (q_r > POS_MAX) ? Q_W'(POS_MAX) : Q_W'(q_r);
    end else begin
      quot = (q_r > NEG_MAG) ? Q_W'(NEG_MAG) : Q_W'(-q_r);
    end
  end

  assign done = done_r;

endmodule

// ===== src/polygon_centroid_top.sv =====
// ----------------------------------------------------------------------------
// polygon_centroid_top: shoelace centroid of a polygon
// Takes vertices one word at a time and returns one center per polygon.
// ----------------------------------------------------------------------------
// Input channel in_*: one vertex per word, signed Q12.4, last_vertex marks
// the closing vertex. Output channel out_*: one word per polygon, sent only
// on the last vertex, with the center and the method that produced it.
// Vertices are handled one at a time; in_stall stays high while one is in
// work. Each edge runs four products through one bit-serial multiplier of
// COORD_BITS+1 steps; the first vertex of a polygon runs no products.
// The last vertex of a polygon with three or more vertices also closes the
// edge back to the first vertex and runs two serial divisions of
// COORD_BITS+1 steps each, but only if the accumulated area is nonzero.
// A result waits in the output register while out_stall is high; the next
// polygon's vertices are taken meanwhile, and only a later result waits
// for the register to drain. Reset clears the accumulators, the vertex
// count and the output valid; vertices past MAX_POINTS are dropped and the
// polygon reports method 4.
// ----------------------------------------------------------------------------
module polygon_centroid_top
  import pcen_pkg::*;
#(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int C      = COORD_BITS;
  localparam int SUM_W  = C + 1;
  localparam int MC_W   = 2 * C + 1;
  localparam int MP_W   = C + 1;
  localparam int PR_W   = MC_W + MP_W;
  localparam int CNT_W  = $clog2(MAX_POINTS + 2);
  localparam int ACC_B  = $clog2(MAX_POINTS);
  localparam int AREA_W = MC_W + ACC_B;
  localparam int WS_W   = PR_W + ACC_B;
  localparam int DEN_W  = AREA_W + 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_MWAIT = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_CLOSE = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_DWAIT = 3'd6;
  localparam logic [2:0] ST_PUSH  = 3'd7;

  localparam logic [1:0] PH_P1    = 2'd0;
  localparam logic [1:0] PH_CROSS = 2'd1;
  localparam logic [1:0] PH_WX    = 2'd2;
  localparam logic [1:0] PH_WY    = 2'd3;

  function automatic logic signed [C-1:0] half_sum(input logic signed [C-1:0] a,
                                                   input logic signed [C-1:0] b);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    s = s + SUM_W'(s[SUM_W-1]);
    half_sum = s[SUM_W-1:1];
  endfunction

  logic [2:0]                state_r, state_nxt;
  logic [1:0]                phase_r, phase_nxt;
  logic                      dphase_r, dphase_nxt;
  logic                      last_r, last_nxt;
  logic                      close_r, close_nxt;
  logic [CNT_W-1:0]          vcount_r, vcount_nxt;
  logic signed [AREA_W-1:0]  area_r, area_nxt;
  logic signed [WS_W-1:0]    wsx_r, wsx_nxt;
  logic signed [WS_W-1:0]    wsy_r, wsy_nxt;
  logic signed [C-1:0]       first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic signed [C-1:0]       prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [C-1:0]       bmin_x_r, bmin_x_nxt, bmax_x_r, bmax_x_nxt;
  logic signed [C-1:0]       bmin_y_r, bmin_y_nxt, bmax_y_r, bmax_y_nxt;
  logic signed [C-1:0]       ax_r, ax_nxt, ay_r, ay_nxt;
  logic signed [C-1:0]       bx_r, bx_nxt, by_r, by_nxt;
  logic signed [MC_W-1:0]    p1_r, p1_nxt;
  logic signed [MC_W-1:0]    cross_r, cross_nxt;
  logic signed [DEN_W-1:0]   den_r, den_nxt;
  logic signed [C-1:0]       cx_r, cx_nxt, cy_r, cy_nxt;
  logic [METHOD_W-1:0]       meth_r, meth_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_word_t                 out_word_r, out_word_nxt;

  logic                      in_acc;
  logic                      slot_free;
  logic signed [C-1:0]       x_in, y_in;
  logic                      mul_start, mul_done;
  logic signed [MC_W-1:0]    mul_mcand;
  logic signed [MP_W-1:0]    mul_mplier;
  logic signed [PR_W-1:0]    mul_prod;
  logic                      div_start, div_done;
  logic signed [WS_W-1:0]    div_num;
  logic signed [C-1:0]       div_quot;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign x_in      = in_word.point_x[C-1:0];
  assign y_in      = in_word.point_y[C-1:0];
  assign div_num   = dphase_r ? wsy_r : wsx_r;

  always_comb begin
    case (phase_r)
      PH_P1: begin
        mul_mcand  = MC_W'(ax_r);
        mul_mplier = MP_W'(by_r);
      end
      PH_CROSS: begin
        mul_mcand  = MC_W'(ay_r);
        mul_mplier = MP_W'(bx_r);
      end
      PH_WX: begin
        mul_mcand  = cross_r;
        mul_mplier = MP_W'(ax_r) + MP_W'(bx_r);
      end
      PH_WY: begin
        mul_mcand  = cross_r;
        mul_mplier = MP_W'(ay_r) + MP_W'(by_r);
      end
      default: begin
        mul_mcand  = '0;
        mul_mplier = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    dphase_nxt    = dphase_r;
    last_nxt      = last_r;
    close_nxt     = close_r;
    vcount_nxt    = vcount_r;
    area_nxt      = area_r;
    wsx_nxt       = wsx_r;
    wsy_nxt       = wsy_r;
    first_x_nxt   = first_x_r;
    first_y_nxt   = first_y_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    bmin_x_nxt    = bmin_x_r;
    bmax_x_nxt    = bmax_x_r;
    bmin_y_nxt    = bmin_y_r;
    bmax_y_nxt    = bmax_y_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    p1_nxt        = p1_r;
    cross_nxt     = cross_r;
    den_nxt       = den_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    meth_nxt      = meth_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          last_nxt  = in_word.last_vertex;
          close_nxt = 1'b0;
          if (vcount_r < CNT_W'(MAX_POINTS)) begin
            prev_x_nxt = x_in;
            prev_y_nxt = y_in;
            vcount_nxt = vcount_r + CNT_W'(1);
            if (vcount_r == '0) begin
              first_x_nxt = x_in;
              first_y_nxt = y_in;
              bmin_x_nxt  = x_in;
              bmax_x_nxt  = x_in;
              bmin_y_nxt  = y_in;
              bmax_y_nxt  = y_in;
              state_nxt   = ST_FIN;
            end else begin
              ax_nxt = prev_x_r;
              ay_nxt = prev_y_r;
              bx_nxt = x_in;
              by_nxt = y_in;
              if (x_in < bmin_x_r) bmin_x_nxt = x_in;
              if (x_in > bmax_x_r) bmax_x_nxt = x_in;
              if (y_in < bmin_y_r) bmin_y_nxt = y_in;
              if (y_in > bmax_y_r) bmax_y_nxt = y_in;
              phase_nxt = PH_P1;
              state_nxt = ST_MUL;
            end
          end else begin
            vcount_nxt = CNT_W'(MAX_POINTS + 1);
            state_nxt  = ST_FIN;
          end
        end
      end
      ST_MUL: begin
        mul_start = 1'b1;
        if (phase_r == PH_WX) begin
          area_nxt = area_r + AREA_W'(cross_r);
        end
        state_nxt = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (mul_done) begin
          case (phase_r)
            PH_P1: begin
              p1_nxt    = $signed(mul_prod[MC_W-1:0]);
              phase_nxt = PH_CROSS;
              state_nxt = ST_MUL;
            end
            PH_CROSS: begin
              cross_nxt = p1_r - $signed(mul_prod[MC_W-1:0]);
              phase_nxt = PH_WX;
              state_nxt = ST_MUL;
            end
            PH_WX: begin
              wsx_nxt   = wsx_r + WS_W'(mul_prod);
              phase_nxt = PH_WY;
              state_nxt = ST_MUL;
            end
            PH_WY: begin
              wsy_nxt   = wsy_r + WS_W'(mul_prod);
              state_nxt = close_r ? ST_CLOSE : ST_FIN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_FIN: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (vcount_r > CNT_W'(MAX_POINTS)) begin
          cx_nxt    = '0;
          cy_nxt    = '0;
          meth_nxt  = METH_OVER;
          state_nxt = ST_PUSH;
        end else if (vcount_r == CNT_W'(1)) begin
          cx_nxt    = first_x_r;
          cy_nxt    = first_y_r;
          meth_nxt  = METH_POINT;
          state_nxt = ST_PUSH;
        end else if (vcount_r == CNT_W'(2)) begin
          cx_nxt    = half_sum(first_x_r, prev_x_r);
          cy_nxt    = half_sum(first_y_r, prev_y_r);
          meth_nxt  = METH_MID;
          state_nxt = ST_PUSH;
        end else begin
          ax_nxt    = prev_x_r;
          ay_nxt    = prev_y_r;
          bx_nxt    = first_x_r;
          by_nxt    = first_y_r;
          close_nxt = 1'b1;
          phase_nxt = PH_P1;
          state_nxt = ST_MUL;
        end
      end
      ST_CLOSE: begin
        if (area_r != '0) begin
          den_nxt    = DEN_W'(area_r) + (DEN_W'(area_r) <<< 1);
          dphase_nxt = 1'b0;
          state_nxt  = ST_DIV;
        end else begin
          cx_nxt    = half_sum(bmin_x_r, bmax_x_r);
          cy_nxt    = half_sum(bmin_y_r, bmax_y_r);
          meth_nxt  = METH_BOX;
          state_nxt = ST_PUSH;
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          if (!dphase_r) begin
            cx_nxt     = div_quot;
            dphase_nxt = 1'b1;
            state_nxt  = ST_DIV;
          end else begin
            cy_nxt    = div_quot;
            meth_nxt  = METH_AREA;
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_word_nxt.center_x = COORD_W'(cx_r);
          out_word_nxt.center_y = COORD_W'(cy_r);
          out_word_nxt.method   = meth_r;
          vcount_nxt            = '0;
          area_nxt              = '0;
          wsx_nxt               = '0;
          wsy_nxt               = '0;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= '0;
      area_r      <= '0;
      wsx_r       <= '0;
      wsy_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      area_r      <= area_nxt;
      wsx_r       <= wsx_nxt;
      wsy_r       <= wsy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    dphase_r   <= dphase_nxt;
    last_r     <= last_nxt;
    close_r    <= close_nxt;
    first_x_r  <= first_x_nxt;
    first_y_r  <= first_y_nxt;
    prev_x_r   <= prev_x_nxt;
    prev_y_r   <= prev_y_nxt;
    bmin_x_r   <= bmin_x_nxt;
    bmax_x_r   <= bmax_x_nxt;
    bmin_y_r   <= bmin_y_nxt;
    bmax_y_r   <= bmax_y_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    p1_r       <= p1_nxt;
    cross_r    <= cross_nxt;
    den_r      <= den_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    meth_r     <= meth_nxt;
    out_word_r <= out_word_nxt;
  end

  pcen_mul #(
    .MC_W (MC_W),
    .MP_W (MP_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .done    (mul_done),
    .product (mul_prod)
  );

  pcen_div #(
    .NUM_W (WS_W),
    .DEN_W (DEN_W),
    .Q_W   (C)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== src/pcen_check.sv =====
// ----------------------------------------------------------------------------
// pcen_check: port-level checks of the polygon centroid block
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module pcen_check
  import pcen_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_one_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second vertex taken while one is in work");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result raised right after a vertex was taken");

  a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.method == METH_OVER |->
      out_word.center_x == '0 && out_word.center_y == '0)
    else $error("overflowed polygon reports a nonzero center");

endmodule

bind polygon_centroid_top pcen_check u_pcen_check (.*);
